// ===== src/ggh_pkg.sv =====
`timescale 1ns / 1ps
package ggh_pkg;

  // default sizes
  localparam int DEF_NUM_ANT      = 32;
  localparam int DEF_PARS_PER_ANT = 2;
  localparam int DEF_NUM_PARAMS   = 64;
  localparam int DEF_Q_DEPTH      = 4;

  // field and accumulator widths
  localparam int NP_W       = 7;   // num_params register
  localparam int IDX_W      = 7;   // antenna * pars + slot, before range check
  localparam int G_TERM_W   = 37;  // gradient term after >>12
  localparam int H_TERM_W   = 36;  // hessian term after >>12
  localparam int CHI_TERM_W = 48;  // exact chi term
  localparam int ACC_W      = 48;  // gradient / hessian sums
  localparam int CHI_W      = 64;
  localparam int USED_W     = 32;
  localparam int STEP_W     = 32;

  // shared divider
  localparam int DIV_RW     = 49;
  localparam int DIV_BITS_W = 64;
  localparam int DIV_IT_W   = 7;
  localparam int ITERS_STEP = 31;
  localparam int ITERS_WIDE = 64;

  // square root
  localparam int SQ_STEPS = 32;
  localparam int SQ_CNT_W = 5;

  localparam logic [NP_W-1:0] NP_RESET = NP_W'(64);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_SOLVE = 2'd2
  } cmd_t;

  typedef enum logic [4:0] {
    B_IDLE, B_A1_RD, B_A1_WR, B_A2_RD, B_A2_WR, B_SCAN, B_DOF, B_KWAIT,
    B_RD, B_LOAD, B_RE, B_RE_W, B_IM, B_IM_W, B_ERR, B_ERR_W, B_SQRT, B_EMIT
  } bstate_t;

  typedef struct packed {
    logic [1:0]         command;
    logic               flagged;
    logic [15:0]        weight;
    logic signed [15:0] resid_re;
    logic signed [15:0] resid_im;
    logic signed [15:0] deriv1_re;
    logic signed [15:0] deriv1_im;
    logic signed [15:0] deriv2_re;
    logic signed [15:0] deriv2_im;
    logic [4:0]         first_antenna;
    logic [4:0]         second_antenna;
    logic               par_slot;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         par_index;
    logic signed [31:0] step_re;
    logic signed [31:0] step_im;
    logic [31:0]        error;
    logic               good;
    logic               last;
  } out_item_t;

  typedef struct packed {
    cmd_t                         op;
    logic signed [G_TERM_W-1:0]   g1_re;
    logic signed [G_TERM_W-1:0]   g1_im;
    logic [H_TERM_W-1:0]          h1;
    logic signed [G_TERM_W-1:0]   g2_re;
    logic signed [G_TERM_W-1:0]   g2_im;
    logic [H_TERM_W-1:0]          h2;
    logic [CHI_TERM_W-1:0]        chi;
    logic [IDX_W-1:0]             idx1;
    logic [IDX_W-1:0]             idx2;
    logic                         use1;
    logic                         use2;
    logic                         count_chi;
  } q_entry_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_RW-1:0]     r0;
    logic [DIV_RW-1:0]     d;
    logic [DIV_BITS_W-1:0] bits;
    logic [DIV_IT_W-1:0]   iters;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_BITS_W-1:0] quot;
  } div_rsp_t;

  function automatic logic signed [ACC_W-1:0] sat_add_g(
      input logic signed [ACC_W-1:0] a, input logic signed [G_TERM_W-1:0] t);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W+1-G_TERM_W){t[G_TERM_W-1]}}, t};
    if (s[ACC_W] != s[ACC_W-1])
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    return s[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_add_h(
      input logic [ACC_W-1:0] a, input logic [H_TERM_W-1:0] t);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {{(ACC_W+1-H_TERM_W){1'b0}}, t};
    if (s[ACC_W])
      return {ACC_W{1'b1}};
    return s[ACC_W-1:0];
  endfunction

  // sign of step is opposite to the gradient; positive results clamp
  function automatic logic signed [STEP_W-1:0] step_fix(
      input logic [STEP_W-1:0] q, input logic signed [ACC_W-1:0] g);
    if (!g[ACC_W-1] && (g != '0))
      return $signed(STEP_W'(0) - q);
    if (q > {1'b0, {(STEP_W-1){1'b1}}})
      return $signed({1'b0, {(STEP_W-1){1'b1}}});
    return $signed(q);
  endfunction

endpackage

// ===== src/gain_gradient_hessian_step_unit.sv =====
`timescale 1ns / 1ps
// Diagonal Gauss-Newton step unit. Accumulate items (command 1) add the
// weighted gradient and diagonal Hessian of one element to the parameters of
// the baseline's two antennas, plus chi-square and the used count when
// par_slot is zero; flagged or zero-weight items are dropped on entry. Clear
// (command 0) zeroes all sums, solve (command 2) emits one item per parameter
// 0..min(num_params, NUM_PARAMS)-1 with step -grad/(2*hess), good flag and
// error sqrt(2*k2/hess), last set on the final one. Structure: a two-stage
// multiply front feeds a four-entry queue; the back end does a read-modify-
// write of two entries in the sums memories per accumulate item, and on
// solve a scan of the good flags and the chi divide, then per parameter
// the two step parts and the error quotient on the one shared bit-serial
// divider, then the square root.
// num_params should only be written while idle.
module gain_gradient_hessian_step_unit import ggh_pkg::*; #(
  parameter int NUM_ANT      = DEF_NUM_ANT,
  parameter int PARS_PER_ANT = DEF_PARS_PER_ANT,
  parameter int NUM_PARAMS   = DEF_NUM_PARAMS,
  parameter int FIFO_DEPTH   = DEF_Q_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item,
  input  logic            cfg_wr_en,
  input  logic [NP_W-1:0] cfg_wr_data
);

  logic [NP_W-1:0] cfg_num_params_r;
  logic q_push, q_pop, q_full, q_empty;
  q_entry_t q_in, q_out;

  // num_params register
  always_ff @(posedge clk) begin
    if (!rst_n)
      cfg_num_params_r <= NP_RESET;
    else if (cfg_wr_en)
      cfg_num_params_r <= cfg_wr_data;
  end

  // front: products, weighting, classification
  ggh_front #(
    .NUM_ANT (NUM_ANT),
    .PARS_PER_ANT (PARS_PER_ANT),
    .NUM_PARAMS (NUM_PARAMS)
  ) u_front (
    .clk (clk),
    .rst_n (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item (in_item),
    .q_push (q_push),
    .q_entry (q_in),
    .q_full (q_full)
  );

  // decoupling queue
  ggh_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk (clk),
    .rst_n (rst_n),
    .push (q_push),
    .din (q_in),
    .full (q_full),
    .pop (q_pop),
    .dout (q_out),
    .empty (q_empty)
  );

  // back: sums memories, solve sequencer
  ggh_back #(
    .NUM_PARAMS (NUM_PARAMS)
  ) u_back (
    .clk (clk),
    .rst_n (rst_n),
    .q_empty (q_empty),
    .q_head (q_out),
    .q_pop (q_pop),
    .cfg_num_params (cfg_num_params_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item (out_item)
  );

  // queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty queue");
  // no result item right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

endmodule

// ===== src/ggh_front.sv =====
`timescale 1ns / 1ps
module ggh_front import ggh_pkg::*; #(
  parameter int NUM_ANT      = DEF_NUM_ANT,
  parameter int PARS_PER_ANT = DEF_PARS_PER_ANT,
  parameter int NUM_PARAMS   = DEF_NUM_PARAMS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     q_push,
  output q_entry_t q_entry,
  input  logic     q_full
);

  logic en1, en2, take, keep;
  cmd_t cmd_in;
  logic [IDX_W-1:0] idx1, idx2;
  logic use1, use2;

  logic s1_v_r, s2_v_r;
  cmd_t s1_cmd_r, s2_cmd_r;
  logic [15:0] s1_w_r;
  logic signed [31:0] s1_rr_d1r_r, s1_ri_d1i_r, s1_ri_d1r_r, s1_rr_d1i_r;
  logic signed [31:0] s1_d1r2_r, s1_d1i2_r;
  logic signed [31:0] s1_rr_d2r_r, s1_ri_d2i_r, s1_rr_d2i_r, s1_ri_d2r_r;
  logic signed [31:0] s1_d2r2_r, s1_d2i2_r, s1_rr2_r, s1_ri2_r;
  logic [IDX_W-1:0] s1_idx1_r, s1_idx2_r, s2_idx1_r, s2_idx2_r;
  logic s1_use1_r, s1_use2_r, s1_cc_r, s2_use1_r, s2_use2_r, s2_cc_r;

  logic signed [16:0] ws;
  logic signed [32:0] sum_g1re, sum_g1im, sum_h1, sum_g2re, sum_g2im, sum_h2, sum_chi;
  logic signed [49:0] s2_g1re_r, s2_g1im_r, s2_h1_r, s2_g2re_r, s2_g2im_r, s2_h2_r;
  logic signed [49:0] s2_chi_r;

  assign en2      = !s2_v_r || !q_full;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;
  assign take     = in_valid && en1;
  assign cmd_in   = cmd_t'(in_item.command);

  // drop reserved commands and skipped elements right here
  always_comb begin
    case (cmd_in)
      CMD_CLEAR: keep = 1'b1;
      CMD_SOLVE: keep = 1'b1;
      CMD_ACC:   keep = !in_item.flagged && (in_item.weight != '0);
      default:   keep = 1'b0;
    endcase
  end

  assign idx1 = IDX_W'(in_item.first_antenna) * IDX_W'(PARS_PER_ANT)
              + IDX_W'(in_item.par_slot);
  assign idx2 = IDX_W'(in_item.second_antenna) * IDX_W'(PARS_PER_ANT)
              + IDX_W'(in_item.par_slot);
  assign use1 = (int'(in_item.first_antenna) < NUM_ANT)
             && (int'(in_item.par_slot) < PARS_PER_ANT) && (int'(idx1) < NUM_PARAMS);
  assign use2 = (int'(in_item.second_antenna) < NUM_ANT)
             && (int'(in_item.par_slot) < PARS_PER_ANT) && (int'(idx2) < NUM_PARAMS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= take && keep;
      if (en2) s2_v_r <= s1_v_r;
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd_r    <= cmd_in;
      s1_w_r      <= in_item.weight;
      s1_rr_d1r_r <= in_item.resid_re * in_item.deriv1_re;
      s1_ri_d1i_r <= in_item.resid_im * in_item.deriv1_im;
      s1_ri_d1r_r <= in_item.resid_im * in_item.deriv1_re;
      s1_rr_d1i_r <= in_item.resid_re * in_item.deriv1_im;
      s1_d1r2_r   <= in_item.deriv1_re * in_item.deriv1_re;
      s1_d1i2_r   <= in_item.deriv1_im * in_item.deriv1_im;
      s1_rr_d2r_r <= in_item.resid_re * in_item.deriv2_re;
      s1_ri_d2i_r <= in_item.resid_im * in_item.deriv2_im;
      s1_rr_d2i_r <= in_item.resid_re * in_item.deriv2_im;
      s1_ri_d2r_r <= in_item.resid_im * in_item.deriv2_re;
      s1_d2r2_r   <= in_item.deriv2_re * in_item.deriv2_re;
      s1_d2i2_r   <= in_item.deriv2_im * in_item.deriv2_im;
      s1_rr2_r    <= in_item.resid_re * in_item.resid_re;
      s1_ri2_r    <= in_item.resid_im * in_item.resid_im;
      s1_idx1_r   <= idx1;
      s1_idx2_r   <= idx2;
      s1_use1_r   <= use1;
      s1_use2_r   <= use2;
      s1_cc_r     <= !in_item.par_slot;
    end
  end

  assign ws       = $signed({1'b0, s1_w_r});
  assign sum_g1re = 33'(s1_rr_d1r_r) + 33'(s1_ri_d1i_r);
  assign sum_g1im = 33'(s1_ri_d1r_r) - 33'(s1_rr_d1i_r);
  assign sum_h1   = 33'(s1_d1r2_r) + 33'(s1_d1i2_r);
  assign sum_g2re = 33'(s1_rr_d2r_r) + 33'(s1_ri_d2i_r);
  assign sum_g2im = 33'(s1_rr_d2i_r) - 33'(s1_ri_d2r_r);
  assign sum_h2   = 33'(s1_d2r2_r) + 33'(s1_d2i2_r);
  assign sum_chi  = 33'(s1_rr2_r) + 33'(s1_ri2_r);

  // stage 2: weighting
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_g1re_r <= ws * sum_g1re;
      s2_g1im_r <= ws * sum_g1im;
      s2_h1_r   <= ws * sum_h1;
      s2_g2re_r <= ws * sum_g2re;
      s2_g2im_r <= ws * sum_g2im;
      s2_h2_r   <= ws * sum_h2;
      s2_chi_r  <= ws * sum_chi;
      s2_idx1_r <= s1_idx1_r;
      s2_idx2_r <= s1_idx2_r;
      s2_use1_r <= s1_use1_r;
      s2_use2_r <= s1_use2_r;
      s2_cc_r   <= s1_cc_r;
    end
  end

  // >>> 12 is the floor shift to Q24.24
  assign q_push            = s2_v_r && !q_full;
  assign q_entry.op        = s2_cmd_r;
  assign q_entry.g1_re     = G_TERM_W'(s2_g1re_r >>> 12);
  assign q_entry.g1_im     = G_TERM_W'(s2_g1im_r >>> 12);
  assign q_entry.h1        = H_TERM_W'(s2_h1_r >>> 12);
  assign q_entry.g2_re     = G_TERM_W'(s2_g2re_r >>> 12);
  assign q_entry.g2_im     = G_TERM_W'(s2_g2im_r >>> 12);
  assign q_entry.h2        = H_TERM_W'(s2_h2_r >>> 12);
  assign q_entry.chi       = CHI_TERM_W'(s2_chi_r);
  assign q_entry.idx1      = s2_idx1_r;
  assign q_entry.idx2      = s2_idx2_r;
  assign q_entry.use1      = s2_use1_r;
  assign q_entry.use2      = s2_use2_r;
  assign q_entry.count_chi = s2_cc_r;

endmodule

// ===== src/ggh_fifo.sv =====
`timescale 1ns / 1ps
module ggh_fifo import ggh_pkg::*; #(
  parameter int DEPTH = DEF_Q_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  output logic     full,
  input  logic     pop,
  output q_entry_t dout,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (push && !pop)
        cnt_r <= cnt_r + CW'(1);
      else if (pop && !push)
        cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== src/ggh_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module ggh_div import ggh_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_RW-1:0] r_r, d_r;
  logic [DIV_BITS_W-1:0] bits_r, q_r;
  logic [DIV_IT_W-1:0] cnt_r;
  logic done_r;
  logic [DIV_RW:0] rs, diff;
  logic ge;

  assign rs   = {r_r, bits_r[DIV_BITS_W-1]};
  assign ge   = rs >= {1'b0, d_r};
  assign diff = rs - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start)
        cnt_r <= req.iters;
      else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_IT_W'(1);
        if (cnt_r == DIV_IT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r_r    <= req.r0;
      d_r    <= req.d;
      bits_r <= req.bits;
      q_r    <= '0;
    end else if (cnt_r != '0) begin
      r_r    <= ge ? diff[DIV_RW-1:0] : rs[DIV_RW-1:0];
      q_r    <= {q_r[DIV_BITS_W-2:0], ge};
      bits_r <= {bits_r[DIV_BITS_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

// ===== src/ggh_back.sv =====
`timescale 1ns / 1ps
module ggh_back import ggh_pkg::*; #(
  parameter int NUM_PARAMS = DEF_NUM_PARAMS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  q_entry_t        q_head,
  output logic            q_pop,
  input  logic [NP_W-1:0] cfg_num_params,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item
);

  localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam int CW = $clog2(NUM_PARAMS + 1);

  bstate_t state_r, state_nxt;
  q_entry_t ent_r, ent_nxt;

  // sums: memories plus per-entry flags
  logic signed [ACC_W-1:0] mem_gre [NUM_PARAMS];
  logic signed [ACC_W-1:0] mem_gim [NUM_PARAMS];
  logic [ACC_W-1:0]        mem_h   [NUM_PARAMS];
  logic signed [ACC_W-1:0] rd_gre_r, rd_gim_r;
  logic [ACC_W-1:0]        rd_h_r;
  logic rd_vld_r;
  logic mem_we;
  logic [AW-1:0] raddr, waddr;
  logic signed [ACC_W-1:0] wg_re, wg_im, eff_gre, eff_gim;
  logic [ACC_W-1:0] wh, eff_h;

  logic [NUM_PARAMS-1:0] vld_r, vld_nxt, hnz_r, hnz_nxt, pg_r, pg_nxt;
  logic [CHI_W-1:0] chi_r, chi_nxt;
  logic [CHI_W:0] chi_sum;
  logic [USED_W-1:0] used_r, used_nxt;

  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] n_r, n_nxt, ngood_r, ngood_nxt, n_cfg;
  logic is_last;
  logic [DIV_BITS_W-1:0] k2_r, k2_nxt;
  logic signed [ACC_W-1:0] g_re_r, g_re_nxt, g_im_r, g_im_nxt, g_sel;
  logic [ACC_W-1:0] h_r, h_nxt, mag;
  logic [DIV_RW-1:0] d2;
  logic ovf;
  logic good_r, good_nxt;
  logic signed [STEP_W-1:0] st_re_r, st_re_nxt, st_im_r, st_im_nxt;
  logic [STEP_W-1:0] err_r, err_nxt;
  logic [32:0] dof;

  logic [DIV_BITS_W-1:0] sq_x_r, sq_x_nxt;
  logic [STEP_W-1:0] sq_root_r, sq_root_nxt;
  logic [33:0] sq_rem_r, sq_rem_nxt;
  logic [35:0] sq_rt, sq_trial;
  logic [SQ_CNT_W-1:0] sq_cnt_r, sq_cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  ggh_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_gre[waddr] <= wg_re;
      mem_gim[waddr] <= wg_im;
      mem_h[waddr]   <= wh;
    end
    rd_gre_r <= mem_gre[raddr];
    rd_gim_r <= mem_gim[raddr];
    rd_h_r   <= mem_h[raddr];
    rd_vld_r <= vld_r[raddr];
  end

  // never-written entries since the last clear read as zero
  assign eff_gre = rd_vld_r ? rd_gre_r : '0;
  assign eff_gim = rd_vld_r ? rd_gim_r : '0;
  assign eff_h   = rd_vld_r ? rd_h_r : '0;

  assign waddr = (state_r == B_A2_WR) ? ent_r.idx2[AW-1:0] : ent_r.idx1[AW-1:0];
  assign wg_re = (state_r == B_A2_WR) ? sat_add_g(eff_gre, ent_r.g2_re)
                                      : sat_add_g(eff_gre, ent_r.g1_re);
  assign wg_im = (state_r == B_A2_WR) ? sat_add_g(eff_gim, ent_r.g2_im)
                                      : sat_add_g(eff_gim, ent_r.g1_im);
  assign wh    = (state_r == B_A2_WR) ? sat_add_h(eff_h, ent_r.h2)
                                      : sat_add_h(eff_h, ent_r.h1);

  assign chi_sum = {1'b0, chi_r} + {{(CHI_W+1-CHI_TERM_W){1'b0}}, ent_r.chi};
  assign n_cfg   = (cfg_num_params > NP_W'(NUM_PARAMS)) ? CW'(NUM_PARAMS)
                                                        : CW'(cfg_num_params);
  assign is_last = (CW'(i_r) + CW'(1)) == n_r;
  assign dof     = (used_r > USED_W'(ngood_r)) ? {used_r - USED_W'(ngood_r), 1'b0}
                                               : 33'd1;

  assign g_sel = ((state_r == B_IM) || (state_r == B_IM_W)) ? g_im_r : g_re_r;
  assign mag   = g_sel[ACC_W-1] ? (~g_sel + ACC_W'(1)) : g_sel;
  assign d2    = {h_r, 1'b0};
  assign ovf   = {8'b0, mag} >= {d2, 7'b0};

  assign sq_rt    = {sq_rem_r, sq_x_r[DIV_BITS_W-1 -: 2]};
  assign sq_trial = {2'b0, sq_root_r, 2'b01};

  always_comb begin
    state_nxt     = state_r;
    ent_nxt       = ent_r;
    vld_nxt       = vld_r;
    hnz_nxt       = hnz_r;
    pg_nxt        = pg_r;
    chi_nxt       = chi_r;
    used_nxt      = used_r;
    i_nxt         = i_r;
    n_nxt         = n_r;
    ngood_nxt     = ngood_r;
    k2_nxt        = k2_r;
    g_re_nxt      = g_re_r;
    g_im_nxt      = g_im_r;
    h_nxt         = h_r;
    good_nxt      = good_r;
    st_re_nxt     = st_re_r;
    st_im_nxt     = st_im_r;
    err_nxt       = err_r;
    sq_x_nxt      = sq_x_r;
    sq_root_nxt   = sq_root_r;
    sq_rem_nxt    = sq_rem_r;
    sq_cnt_nxt    = sq_cnt_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    raddr         = i_r;
    q_pop         = 1'b0;
    div_req       = '0;

    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_head;
          case (q_head.op)
            CMD_CLEAR: begin
              vld_nxt  = '0;
              hnz_nxt  = '0;
              chi_nxt  = '0;
              used_nxt = '0;
            end
            CMD_ACC: state_nxt = B_A1_RD;
            CMD_SOLVE: begin
              n_nxt     = n_cfg;
              i_nxt     = '0;
              ngood_nxt = '0;
              if (n_cfg != '0) state_nxt = B_SCAN;
            end
            default: ;
          endcase
        end
      end
      B_A1_RD: begin
        raddr = ent_r.idx1[AW-1:0];
        if (ent_r.count_chi) begin
          chi_nxt = chi_sum[CHI_W] ? {CHI_W{1'b1}} : chi_sum[CHI_W-1:0];
          if (used_r != {USED_W{1'b1}}) used_nxt = used_r + USED_W'(1);
        end
        state_nxt = ent_r.use1 ? B_A1_WR : B_A2_RD;
      end
      B_A1_WR: begin
        mem_we         = 1'b1;
        vld_nxt[waddr] = 1'b1;
        hnz_nxt[waddr] = (wh != '0);
        state_nxt      = B_A2_RD;
      end
      B_A2_RD: begin
        raddr     = ent_r.idx2[AW-1:0];
        state_nxt = ent_r.use2 ? B_A2_WR : B_IDLE;
      end
      B_A2_WR: begin
        mem_we         = 1'b1;
        vld_nxt[waddr] = 1'b1;
        hnz_nxt[waddr] = (wh != '0);
        state_nxt      = B_IDLE;
      end
      B_SCAN: begin
        // a zero Hessian clears the good flag for good
        pg_nxt[i_r] = pg_r[i_r] & hnz_r[i_r];
        if (pg_r[i_r] && hnz_r[i_r]) ngood_nxt = ngood_r + CW'(1);
        if (is_last) begin
          i_nxt     = '0;
          state_nxt = B_DOF;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      B_DOF: begin
        div_req.start = 1'b1;
        div_req.r0    = '0;
        div_req.d     = DIV_RW'(dof);
        div_req.bits  = chi_r;
        div_req.iters = DIV_IT_W'(ITERS_WIDE);
        state_nxt     = B_KWAIT;
      end
      B_KWAIT: begin
        if (div_rsp.done) begin
          k2_nxt    = div_rsp.quot;
          state_nxt = B_RD;
        end
      end
      B_RD: state_nxt = B_LOAD;
      B_LOAD: begin
        g_re_nxt  = eff_gre;
        g_im_nxt  = eff_gim;
        h_nxt     = eff_h;
        good_nxt  = pg_r[i_r];
        state_nxt = B_RE;
      end
      B_RE, B_IM: begin
        if (!good_r || ovf) begin
          if (state_r == B_RE)
            st_re_nxt = good_r ? step_fix(32'h8000_0000, g_sel) : '0;
          else
            st_im_nxt = good_r ? step_fix(32'h8000_0000, g_sel) : '0;
          state_nxt = (state_r == B_RE) ? B_IM : B_ERR;
        end else begin
          div_req.start = 1'b1;
          div_req.r0    = DIV_RW'(mag[ACC_W-1:7]);
          div_req.d     = d2;
          div_req.bits  = {mag[6:0], {(DIV_BITS_W-7){1'b0}}};
          div_req.iters = DIV_IT_W'(ITERS_STEP);
          state_nxt     = (state_r == B_RE) ? B_RE_W : B_IM_W;
        end
      end
      B_RE_W: begin
        if (div_rsp.done) begin
          st_re_nxt = step_fix(div_rsp.quot[STEP_W-1:0], g_sel);
          state_nxt = B_IM;
        end
      end
      B_IM_W: begin
        if (div_rsp.done) begin
          st_im_nxt = step_fix(div_rsp.quot[STEP_W-1:0], g_sel);
          state_nxt = B_ERR;
        end
      end
      B_ERR: begin
        if (h_r == '0) begin
          err_nxt   = '0;
          state_nxt = B_EMIT;
        end else if ({11'b0, k2_r} >= {h_r, 27'b0}) begin
          err_nxt   = '1;
          state_nxt = B_EMIT;
        end else begin
          div_req.start = 1'b1;
          div_req.r0    = DIV_RW'(k2_r[DIV_BITS_W-1:27]);
          div_req.d     = DIV_RW'(h_r);
          div_req.bits  = {k2_r[26:0], 37'b0};
          div_req.iters = DIV_IT_W'(ITERS_WIDE);
          state_nxt     = B_ERR_W;
        end
      end
      B_ERR_W: begin
        if (div_rsp.done) begin
          sq_x_nxt    = div_rsp.quot;
          sq_root_nxt = '0;
          sq_rem_nxt  = '0;
          sq_cnt_nxt  = '0;
          state_nxt   = B_SQRT;
        end
      end
      B_SQRT: begin
        // two radicand bits per step
        if (sq_rt >= sq_trial) begin
          sq_rem_nxt  = 34'(sq_rt - sq_trial);
          sq_root_nxt = {sq_root_r[STEP_W-2:0], 1'b1};
        end else begin
          sq_rem_nxt  = sq_rt[33:0];
          sq_root_nxt = {sq_root_r[STEP_W-2:0], 1'b0};
        end
        sq_x_nxt   = {sq_x_r[DIV_BITS_W-3:0], 2'b00};
        sq_cnt_nxt = sq_cnt_r + SQ_CNT_W'(1);
        if (sq_cnt_r == SQ_CNT_W'(SQ_STEPS - 1)) begin
          err_nxt   = sq_root_nxt;
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.par_index = 6'(i_r);
          out_item_nxt.step_re   = st_re_r;
          out_item_nxt.step_im   = st_im_r;
          out_item_nxt.error     = err_r;
          out_item_nxt.good      = good_r;
          out_item_nxt.last      = is_last;
          if (is_last) begin
            state_nxt = B_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = B_RD;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      vld_r       <= '0;
      hnz_r       <= '0;
      pg_r        <= '1;
      chi_r       <= '0;
      used_r      <= '0;
      i_r         <= '0;
      n_r         <= '0;
      ngood_r     <= '0;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      hnz_r       <= hnz_nxt;
      pg_r        <= pg_nxt;
      chi_r       <= chi_nxt;
      used_r      <= used_nxt;
      i_r         <= i_nxt;
      n_r         <= n_nxt;
      ngood_r     <= ngood_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r      <= ent_nxt;
    k2_r       <= k2_nxt;
    g_re_r     <= g_re_nxt;
    g_im_r     <= g_im_nxt;
    h_r        <= h_nxt;
    good_r     <= good_nxt;
    st_re_r    <= st_re_nxt;
    st_im_r    <= st_im_nxt;
    err_r      <= err_nxt;
    sq_x_r     <= sq_x_nxt;
    sq_root_r  <= sq_root_nxt;
    sq_rem_r   <= sq_rem_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Gauss-Newton step unit testbench.
// Items go through a queue to a clocked driver. A clocked monitor predicts
// each accepted item and checks each result item in order.
module tb_top;
  import ggh_pkg::*;

  localparam int  CLK_HALF  = 5;
  localparam int  RST_CYC   = 5;
  localparam int  DRAIN_CYC = 400;      // let queued items reach the back end
  localparam int  MAX_CYC   = 2000000;
  localparam int  LONG_HOLD = 3000;     // receiver hold-off during the pressure phase
  localparam logic [1:0] CMD_NONE = 2'd3;   // undefined command, ignored
  localparam int  N_PAR     = 64;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_item = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_item;
  logic            cfg_wr_en = 1'b0;
  logic [NP_W-1:0] cfg_wr_data = '0;

  always #CLK_HALF clk = ~clk;

  gain_gradient_hessian_step_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // model of the sums
  longint          grad_re_m [N_PAR] = '{default: 0};
  longint          grad_im_m [N_PAR] = '{default: 0};
  longint unsigned hess_m    [N_PAR] = '{default: 0};
  bit              good_m    [N_PAR] = '{default: 1'b1};
  longint unsigned chi_m = 0;
  int unsigned     used_m = 0;
  logic [NP_W-1:0] np_m;

  in_item_t  pending_items[$];
  out_item_t expected_steps[$];

  int  gap_left, hold_left;
  bit  no_idle;
  int  stall_req, stall_seen;
  int  n_errors = 0, n_checked = 0, n_acc = 0, n_solve = 0;
  longint cycles = 0;

  // -- arithmetic --
  function automatic longint sat48(longint a, longint b);
    longint s;
    s = a + b;
    if (s > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return s;
  endfunction

  function automatic logic [31:0] step_from(longint g, longint unsigned h);
    longint unsigned d, mag, q, r;
    d = 2 * h;
    mag = (g < 0) ? longint'(-g) : longint'(g);
    if (mag >= (d << 7)) begin
      q = 64'h8000_0000;
    end else begin
      q = mag / d;
      r = mag % d;
      for (int k = 0; k < 24; k++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
      end
    end
    if (g > 0) return 32'(64'd0 - q);
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] error_from(longint unsigned k2, longint unsigned h);
    longint unsigned q, r;
    if (h == 0) return 32'd0;
    q = k2 / h;
    r = k2 % h;
    if (q >= (64'd1 << 27)) return 32'hFFFF_FFFF;
    for (int k = 0; k < 37; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= h) begin
        r = r - h;
        q = q | 64'd1;
      end
    end
    return 32'(int_sqrt(q));
  endfunction

  // adds one antenna's terms; all 5-bit antennas and both slots are in range
  function automatic void add_param(int idx, longint gr, longint gi, longint h);
    longint unsigned hs;
    grad_re_m[idx] = sat48(grad_re_m[idx], gr);
    grad_im_m[idx] = sat48(grad_im_m[idx], gi);
    hs = hess_m[idx] + longint'(h);
    hess_m[idx] = (hs > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : hs;
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < N_PAR; i++) begin
      grad_re_m[i] = 0;
      grad_im_m[i] = 0;
      hess_m[i] = 0;
    end
    chi_m = 0;
    used_m = 0;
  endfunction

  // works out the result items of one accepted item
  function automatic void predict_steps(in_item_t it);
    longint w, rr, ri, ar, ai, br, bi;
    longint unsigned c, cs, dof, k2;
    int n, ngood;
    out_item_t o;
    w = longint'(it.weight);
    rr = it.resid_re;  ri = it.resid_im;
    ar = it.deriv1_re; ai = it.deriv1_im;
    br = it.deriv2_re; bi = it.deriv2_im;
    case (it.command)
      CMD_CLEAR: clear_sums();
      CMD_ACC: begin
        n_acc++;
        if (!it.flagged && it.weight != 0) begin
          // >>> on a signed value floors, as the unit does
          add_param(it.first_antenna * 2 + it.par_slot,
                    (w * (rr * ar + ri * ai)) >>> 12,
                    (w * (ri * ar - rr * ai)) >>> 12,
                    (w * (ar * ar + ai * ai)) >>> 12);
          add_param(it.second_antenna * 2 + it.par_slot,
                    (w * (br * rr + bi * ri)) >>> 12,
                    (w * (bi * rr - br * ri)) >>> 12,
                    (w * (br * br + bi * bi)) >>> 12);
          if (!it.par_slot) begin
            c = w * (rr * rr + ri * ri);
            cs = chi_m + c;
            chi_m = (cs < chi_m) ? 64'hFFFF_FFFF_FFFF_FFFF : cs;
            if (used_m != 32'hFFFF_FFFF) used_m++;
          end
        end
      end
      CMD_SOLVE: begin
        n_solve++;
        n = (np_m > N_PAR) ? N_PAR : np_m;
        ngood = 0;
        for (int i = 0; i < n; i++)
          if (hess_m[i] == 0) good_m[i] = 1'b0;
        for (int i = 0; i < n; i++) ngood += good_m[i];
        dof = (used_m > ngood) ? 2 * longint'(used_m - ngood) : 1;
        k2 = chi_m / dof;
        for (int i = 0; i < n; i++) begin
          o.par_index = 6'(i);
          o.good = good_m[i];
          o.last = (i + 1 == n);
          o.step_re = good_m[i] ? step_from(grad_re_m[i], hess_m[i]) : '0;
          o.step_im = good_m[i] ? step_from(grad_im_m[i], hess_m[i]) : '0;
          o.error = error_from(k2, hess_m[i]);
          expected_steps.push_back(o);
        end
      end
      default: ;
    endcase
  endfunction

  // -- sender --
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the item until taken
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() > 0) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      // mostly short gaps, a few long ones
      if (no_idle || $urandom_range(0, 2) == 0) gap_left <= 0;
      else if ($urandom_range(0, 15) == 0) gap_left <= $urandom_range(10, 40);
      else gap_left <= $urandom_range(1, 3);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // -- receiver --
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      stall_seen <= 0;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (no_idle || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      hold_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
    end
  end

  // -- monitor: check results, then predict the accepted item --
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result item %p", out_item);
        end else begin
          want = expected_steps.pop_front();
          n_checked++;
          if (out_item.par_index !== want.par_index || out_item.step_re !== want.step_re ||
              out_item.step_im !== want.step_im || out_item.error !== want.error ||
              out_item.good !== want.good || out_item.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected %p, got %p", want, out_item);
          end
        end
      end
      if (in_valid && in_ready) predict_steps(in_item);
    end
  end

  // -- run limit --
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // -- stimulus helpers --
  function automatic in_item_t make_cmd(logic [1:0] c);
    in_item_t it;
    it = '0;
    it.command = c;
    return it;
  endfunction

  // random accumulate aimed at parameters below np
  function automatic in_item_t make_acc(int np);
    in_item_t it;
    int top;
    it = make_cmd(CMD_ACC);
    top = (np < 2) ? 0 : (np > N_PAR ? 31 : (np - 1) / 2);
    it.flagged = ($urandom_range(0, 15) == 0);
    it.weight = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
    it.resid_re = 16'($urandom);   it.resid_im = 16'($urandom);
    it.deriv1_re = 16'($urandom);  it.deriv1_im = 16'($urandom);
    it.deriv2_re = 16'($urandom);  it.deriv2_im = 16'($urandom);
    it.first_antenna = 5'($urandom_range(0, top));
    it.second_antenna = 5'($urandom_range(0, top));
    it.par_slot = (np < 2) ? 1'b0 : 1'($urandom);
    if ($urandom_range(0, 20) == 0) it.command = CMD_NONE;
    return it;
  endfunction

  function automatic in_item_t make_fixed(logic [15:0] w, logic [15:0] v, logic [4:0] a1,
                                          logic [4:0] a2, logic s);
    in_item_t it;
    it = make_cmd(CMD_ACC);
    it.weight = w;
    it.resid_re = v;  it.resid_im = v;
    it.deriv1_re = v; it.deriv1_im = ~v;
    it.deriv2_re = ~v; it.deriv2_im = v;
    it.first_antenna = a1;
    it.second_antenna = a2;
    it.par_slot = s;
    return it;
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() > 0 || in_valid || expected_steps.size() > 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_np(logic [NP_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    np_m = v;
  endtask

  initial begin
    in_item_t it;
    int np_list[12];
    int np;
    np_list = '{2, 1, 0, 6, 10, 16, 24, 32, 40, 48, 56, 127};
    np_m = NP_RESET;
    stall_req = 0; no_idle = 1'b0;
    repeat (RST_CYC) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes on parameters 0..3, then a solve with n = 4
    write_np(7'd4);
    pending_items.push_back(make_cmd(CMD_SOLVE));      // all sums zero: no good params
    pending_items.push_back(make_cmd(CMD_CLEAR));
    pending_items.push_back(make_fixed(16'hFFFF, 16'h8000, 5'd0, 5'd1, 1'b0));
    pending_items.push_back(make_fixed(16'hFFFF, 16'h7FFF, 5'd1, 5'd0, 1'b1));
    pending_items.push_back(make_fixed(16'h0001, 16'h0001, 5'd0, 5'd0, 1'b1));
    pending_items.push_back(make_fixed(16'h0000, 16'h7FFF, 5'd1, 5'd1, 1'b0)); // no weight
    it = make_fixed(16'h0100, 16'h4000, 5'd0, 5'd1, 1'b0);
    it.flagged = 1'b1;                                // flagged element
    pending_items.push_back(it);
    it = make_fixed(16'hFFFF, 16'h8000, 5'd31, 5'd31, 1'b1);
    it.command = CMD_NONE;                            // ignored command
    pending_items.push_back(it);
    pending_items.push_back(make_fixed(16'h8000, 16'hFFFF, 5'd1, 5'd0, 1'b0));
    pending_items.push_back(make_cmd(CMD_SOLVE));
    // used count not above good count: dof of one
    pending_items.push_back(make_cmd(CMD_CLEAR));
    pending_items.push_back(make_fixed(16'h0100, 16'h2000, 5'd0, 5'd1, 1'b1));
    pending_items.push_back(make_fixed(16'h0100, 16'hC000, 5'd1, 5'd0, 1'b1));
    pending_items.push_back(make_cmd(CMD_SOLVE));
    wait_idle();

    // random: clear, accumulate, solve sequences over a list of sizes from 0 to 127
    foreach (np_list[s]) begin
      np = np_list[s];
      no_idle = (s % 4 == 3);
      write_np(7'(np));
      if ($urandom_range(0, 3) != 0) pending_items.push_back(make_cmd(CMD_CLEAR));
      for (int k = 0; k < 11; k++) pending_items.push_back(make_acc(np));
      pending_items.push_back(make_cmd(CMD_SOLVE));
      wait_idle();
    end
    no_idle = 1'b0;

    // pressure: full solve, receiver held off while accumulates keep coming
    write_np(7'd64);
    pending_items.push_back(make_cmd(CMD_SOLVE));
    stall_req = stall_req + 1;
    for (int k = 0; k < 20; k++) pending_items.push_back(make_acc(64));
    pending_items.push_back(make_cmd(CMD_SOLVE));
    wait_idle();

    $display("%0d accumulate items and %0d solves sent, %0d result items checked",
             n_acc, n_solve, n_checked);
    $display("parameter counts 0 to 127 used, with a long receiver hold-off");
    if (n_errors == 0 && expected_steps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", n_errors + expected_steps.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
